@@ src/lppd_pkg.sv @@
package lppd_pkg;

	localparam int unsigned HDR_BYTES = 11;
	localparam int unsigned MIN_BYTES = 13;
	localparam int unsigned CHK_BYTES = 2;

	// byte index only matters up to the too-short decision, so it saturates there
	localparam int unsigned POS_W = 4;
	localparam logic [POS_W-1:0] POS_SAT = POS_W'(MIN_BYTES - 1);
	localparam logic [POS_W-1:0] POS_KIND = POS_W'(2);
	localparam logic [POS_W-1:0] POS_SEQ_END = POS_W'(7);
	localparam logic [POS_W-1:0] POS_LEN_LAST = POS_W'(HDR_BYTES - 1);

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_REPORT = 1'b1;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_TOO_SHORT = 2'd1;
	localparam logic [1:0] ST_LEN_MISMATCH = 2'd2;

	typedef enum logic [3:0] {
		PH_HDR  = 4'b0001,
		PH_BODY = 4'b0010,
		PH_CHK  = 4'b0100,
		PH_DONE = 4'b1000
	} phase_t;

	typedef struct packed {
		logic        result_kind;
		logic [7:0]  payload_byte;
		logic [1:0]  status;
		logic [15:0] proto_version;
		logic [7:0]  packet_kind;
		logic [31:0] sequence_number;
		logic [31:0] payload_length;
		logic [15:0] check_value;
		logic        frame_last;
	} res_t;

endpackage

@@ src/lppd_in_if.sv @@
interface lppd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       buffer_end;

	modport source (output valid, output rx_byte, output buffer_end, input ready);
	modport sink (input valid, input rx_byte, input buffer_end, output ready);
endinterface

@@ src/lppd_out_if.sv @@
interface lppd_out_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic [7:0]  payload_byte;
	logic [1:0]  status;
	logic [15:0] proto_version;
	logic [7:0]  packet_kind;
	logic [31:0] sequence_number;
	logic [31:0] payload_length;
	logic [15:0] check_value;
	logic        frame_last;

	modport source (output valid, output result_kind, output payload_byte, output status,
		output proto_version, output packet_kind, output sequence_number,
		output payload_length, output check_value, output frame_last, input ready);
	modport sink (input valid, input result_kind, input payload_byte, input status,
		input proto_version, input packet_kind, input sequence_number,
		input payload_length, input check_value, input frame_last, output ready);
endinterface

@@ src/lppd_parser.sv @@
module lppd_parser
	import lppd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       acc,
	input  logic [7:0] rx_byte,
	input  logic       buffer_end,
	output logic       res_valid,
	output res_t       res
);

	phase_t          phase_q, phase_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic [15:0]     ver_q, ver_d;
	logic [7:0]      kind_q, kind_d;
	logic [31:0]     seq_q, seq_d;
	logic [31:0]     len_q, len_d;
	logic [31:0]     rem_q, rem_d;
	logic [15:0]     chk_q, chk_d;
	logic            completes;
	logic            is_payload;

	always_comb begin
		phase_d = phase_q;
		ver_d = ver_q;
		kind_d = kind_q;
		seq_d = seq_q;
		len_d = len_q;
		rem_d = rem_q;
		chk_d = chk_q;
		completes = 1'b0;
		is_payload = 1'b0;
		case (phase_q)
			PH_HDR: begin
				if (pos_q < POS_KIND) begin
					ver_d = {ver_q[7:0], rx_byte};
				end else if (pos_q == POS_KIND) begin
					kind_d = rx_byte;
				end else if (pos_q < POS_SEQ_END) begin
					seq_d = {seq_q[23:0], rx_byte};
				end else begin
					len_d = {len_q[23:0], rx_byte};
					if (pos_q == POS_LEN_LAST) begin
						rem_d = len_d;
						phase_d = PH_BODY;
					end
				end
			end
			PH_BODY: begin
				if (rem_q != '0) begin
					is_payload = 1'b1;
					rem_d = rem_q - 32'd1;
				end else begin
					// first check byte
					chk_d = {chk_q[7:0], rx_byte};
					phase_d = PH_CHK;
				end
			end
			PH_CHK: begin
				chk_d = {chk_q[7:0], rx_byte};
				completes = 1'b1;
				phase_d = PH_DONE;
			end
			PH_DONE: begin
				phase_d = PH_DONE;
			end
			default: begin
				phase_d = PH_HDR;
			end
		endcase

		pos_d = (pos_q == POS_SAT) ? pos_q : pos_q + POS_W'(1);
		if (buffer_end) begin
			phase_d = PH_HDR;
			pos_d = '0;
		end
	end

	always_comb begin
		res = '0;
		res_valid = 1'b0;
		if (completes) begin
			res_valid = 1'b1;
			res.result_kind = KIND_REPORT;
			res.status = ST_OK;
			res.proto_version = ver_d;
			res.packet_kind = kind_d;
			res.sequence_number = seq_d;
			res.payload_length = len_d;
			res.check_value = chk_d;
			res.frame_last = 1'b1;
		end else if (buffer_end && phase_q != PH_DONE) begin
			// short buffer: the report replaces any payload byte here
			res_valid = 1'b1;
			res.result_kind = KIND_REPORT;
			res.status = (pos_q < POS_SAT) ? ST_TOO_SHORT : ST_LEN_MISMATCH;
			res.frame_last = 1'b1;
		end else if (is_payload) begin
			res_valid = 1'b1;
			res.result_kind = KIND_PAYLOAD;
			res.payload_byte = rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR;
			pos_q <= '0;
		end else if (acc) begin
			phase_q <= phase_d;
			pos_q <= pos_d;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ver_q <= ver_d;
			kind_q <= kind_d;
			seq_q <= seq_d;
			len_q <= len_d;
			rem_q <= rem_d;
			chk_q <= chk_d;
		end
	end

endmodule

@@ src/lppd_out_reg.sv @@
module lppd_out_reg
	import lppd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  res_t res,
	input  logic out_ready,
	output logic in_ready,
	output logic out_valid,
	output res_t out_res
);

	logic valid_q;
	res_t res_q;

	// a new request can enter when no result is held or when the held result leaves in the same cycle
	assign in_ready = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && load) begin
			res_q <= res;
		end
	end

endmodule

@@ src/length_prefixed_packet_deframer_unit.sv @@
// Length-prefixed packet deframer.
// in: one received byte per request (rx_byte) with buffer_end marking the last
//   byte of a buffer. Header is big-endian: version(2) type(1) seq(4) len(4),
//   then len payload bytes, then a 2-byte check value (carried, not verified).
// out: zero or one result per input byte. result_kind 0 passes a payload byte;
//   result_kind 1 is a frame report (status ok with header fields and check
//   value, or too_short / length_mismatch with zeroed fields), frame_last = 1.
// Throughput: one byte per cycle unless stalled. A result is valid the cycle
//   after its byte is taken (one result register after the parse logic).
// The payload count runs down a 32-bit counter loaded when the length field
//   is complete; the header position counter saturates at 12.
// Stall: while out.ready is low and a result is held, in.ready drops; when
//   the held result is taken, a new byte is accepted in that same cycle.
// Reset: arst_n clears the parse phase, the position counter and the result
//   valid flag; the block is ready for the first byte of a buffer right away.
// After buffer_end the parser returns to the header phase for the next buffer.
module length_prefixed_packet_deframer_unit
	import lppd_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	lppd_in_if.sink    in,
	lppd_out_if.source out
);

	logic acc;
	logic res_valid;
	logic in_ready;
	res_t res;
	res_t out_res;

	assign in.ready = in_ready;
	assign acc = in.valid && in_ready;

	lppd_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.acc        (acc),
		.rx_byte    (in.rx_byte),
		.buffer_end (in.buffer_end),
		.res_valid  (res_valid),
		.res        (res)
	);

	lppd_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (acc && res_valid),
		.res       (res),
		.out_ready (out.ready),
		.in_ready  (in_ready),
		.out_valid (out.valid),
		.out_res   (out_res)
	);

	assign out.result_kind = out_res.result_kind;
	assign out.payload_byte = out_res.payload_byte;
	assign out.status = out_res.status;
	assign out.proto_version = out_res.proto_version;
	assign out.packet_kind = out_res.packet_kind;
	assign out.sequence_number = out_res.sequence_number;
	assign out.payload_length = out_res.payload_length;
	assign out.check_value = out_res.check_value;
	assign out.frame_last = out_res.frame_last;

endmodule

@@ src/lppd_checker.sv @@
module lppd_checker
	import lppd_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        result_kind,
	input logic [7:0]  payload_byte,
	input logic [1:0]  status,
	input logic [15:0] proto_version,
	input logic [7:0]  packet_kind,
	input logic [31:0] sequence_number,
	input logic [31:0] payload_length,
	input logic [15:0] check_value,
	input logic        frame_last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(payload_byte) && $stable(status)
			&& $stable(result_kind) && $stable(check_value))
		else $error("result changed while stalled");

	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_PAYLOAD |-> status == ST_OK && !frame_last
			&& proto_version == '0 && sequence_number == '0 && payload_length == '0
			&& check_value == '0 && packet_kind == '0)
		else $error("payload result carries report fields");

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_REPORT && status != ST_OK |-> payload_byte == '0
			&& proto_version == '0 && sequence_number == '0 && payload_length == '0
			&& check_value == '0 && packet_kind == '0)
		else $error("error report carries header fields");

	a_report_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> frame_last == result_kind
			&& (status == ST_OK || status == ST_TOO_SHORT || status == ST_LEN_MISMATCH))
		else $error("frame_last or status inconsistent");

endmodule

bind length_prefixed_packet_deframer_unit lppd_checker u_lppd_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out.valid),
	.out_ready       (out.ready),
	.result_kind     (out.result_kind),
	.payload_byte    (out.payload_byte),
	.status          (out.status),
	.proto_version   (out.proto_version),
	.packet_kind     (out.packet_kind),
	.sequence_number (out.sequence_number),
	.payload_length  (out.payload_length),
	.check_value     (out.check_value),
	.frame_last      (out.frame_last)
);

@@ dv/lppd_frame_checker.sv @@
module lppd_frame_checker
	import lppd_pkg::*;
(
	input logic  clk,
	input logic  arst_n,
	lppd_in_if   in_ch,
	lppd_out_if  out_ch,
	output int   mismatches,
	output int   outstanding
);

	localparam logic [32:0] POS_LIMIT = {33{1'b1}};

	logic [32:0] pos;
	logic [15:0] version_q;
	logic [7:0]  kind_q;
	logic [31:0] seq_q;
	logic [31:0] len_q;
	logic [15:0] check_q;
	logic        done_q;

	res_t deframer_results_q[$];

	task automatic clear_parser();
		pos = '0;
		version_q = '0;
		kind_q = '0;
		seq_q = '0;
		len_q = '0;
		check_q = '0;
		done_q = 1'b0;
	endtask

	function automatic void queue_result(input res_t r);
		deframer_results_q = {deframer_results_q, r};
	endfunction

	task automatic deframe_byte(input logic [7:0] b, input logic last);
		logic [32:0] idx;
		logic [32:0] body_end;
		logic [32:0] n;
		logic        was_done;
		logic        completes;
		logic        is_payload;
		res_t        r;
		idx = pos;
		body_end = 33'(HDR_BYTES) + {1'b0, len_q};
		was_done = done_q;
		completes = 1'b0;
		is_payload = 1'b0;
		if (!done_q) begin
			if (idx < 2) begin
				version_q = {version_q[7:0], b};
			end else if (idx == 2) begin
				kind_q = b;
			end else if (idx < 7) begin
				seq_q = {seq_q[23:0], b};
			end else if (idx < 33'(HDR_BYTES)) begin
				len_q = {len_q[23:0], b};
			end else if (idx < body_end) begin
				is_payload = 1'b1;
			end else if (idx == body_end) begin
				check_q = {check_q[7:0], b};
			end else if (idx == body_end + 1) begin
				check_q = {check_q[7:0], b};
				completes = 1'b1;
				done_q = 1'b1;
			end
		end

		r = '0;
		if (completes) begin
			r.result_kind = KIND_REPORT;
			r.status = ST_OK;
			r.proto_version = version_q;
			r.packet_kind = kind_q;
			r.sequence_number = seq_q;
			r.payload_length = len_q;
			r.check_value = check_q;
			r.frame_last = 1'b1;
			queue_result(r);
		end else if (last && !was_done) begin
			// truncated buffer: error report replaces any payload byte here
			n = (idx < POS_LIMIT) ? idx + 1 : POS_LIMIT;
			r.result_kind = KIND_REPORT;
			r.status = (n < 33'(MIN_BYTES)) ? ST_TOO_SHORT : ST_LEN_MISMATCH;
			r.frame_last = 1'b1;
			queue_result(r);
		end else if (is_payload) begin
			r.result_kind = KIND_PAYLOAD;
			r.payload_byte = b;
			queue_result(r);
		end

		if (pos < POS_LIMIT)
			pos = pos + 1;
		if (last)
			clear_parser();
	endtask

	task automatic report_result(input string what, input res_t e, input res_t g);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t: %s", $time, what);
			$display("  exp kind=%0d byte=%h st=%0d ver=%h type=%h seq=%h len=%h chk=%h last=%0d",
				e.result_kind, e.payload_byte, e.status, e.proto_version, e.packet_kind,
				e.sequence_number, e.payload_length, e.check_value, e.frame_last);
			$display("  got kind=%0d byte=%h st=%0d ver=%h type=%h seq=%h len=%h chk=%h last=%0d",
				g.result_kind, g.payload_byte, g.status, g.proto_version, g.packet_kind,
				g.sequence_number, g.payload_length, g.check_value, g.frame_last);
		end
	endtask

	task automatic check_result();
		res_t got;
		res_t want;
		logic bad;
		got.result_kind = out_ch.result_kind;
		got.payload_byte = out_ch.payload_byte;
		got.status = out_ch.status;
		got.proto_version = out_ch.proto_version;
		got.packet_kind = out_ch.packet_kind;
		got.sequence_number = out_ch.sequence_number;
		got.payload_length = out_ch.payload_length;
		got.check_value = out_ch.check_value;
		got.frame_last = out_ch.frame_last;
		if (deframer_results_q.size() == 0) begin
			report_result("result with nothing expected", '0, got);
		end else begin
			want = deframer_results_q.pop_front();
			bad = (got.result_kind !== want.result_kind) ||
				(got.payload_byte !== want.payload_byte) ||
				(got.status !== want.status) ||
				(got.proto_version !== want.proto_version) ||
				(got.packet_kind !== want.packet_kind) ||
				(got.sequence_number !== want.sequence_number) ||
				(got.payload_length !== want.payload_length) ||
				(got.check_value !== want.check_value) ||
				(got.frame_last !== want.frame_last);
			if (bad)
				report_result("result mismatch", want, got);
		end
	endtask

	initial begin
		mismatches = 0;
		outstanding = 0;
		clear_parser();
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_parser();
			deframer_results_q.delete();
		end else begin
			if (in_ch.valid && in_ch.ready)
				deframe_byte(in_ch.rx_byte, in_ch.buffer_end);
			if (out_ch.valid && out_ch.ready)
				check_result();
		end
		outstanding = deframer_results_q.size();
	end

endmodule

@@ dv/length_prefixed_packet_deframer_unit_test.sv @@
module length_prefixed_packet_deframer_unit_test;
	import lppd_pkg::*;

	localparam int PHASE_BYTES = 250;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	idle_mode_t idle_mode = IDLE_NONE;
	logic [7:0] frame_bytes[$];
	int         bytes_sent = 0;
	int         mismatches;
	int         outstanding;

	lppd_in_if  in_ch();
	lppd_out_if out_ch();

	length_prefixed_packet_deframer_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in     (in_ch),
		.out    (out_ch)
	);

	lppd_frame_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_ch),
		.out_ch      (out_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit chance(input int pct);
		return $urandom_range(99) < pct;
	endfunction

	function automatic bit sender_idles();
		case (idle_mode)
			IDLE_SENDER: return chance(79);
			IDLE_BOTH:   return chance(24);
			default:     return 1'b0;
		endcase
	endfunction

	function automatic bit receiver_stalls();
		case (idle_mode)
			IDLE_RECEIVER: return chance(79);
			IDLE_BOTH:     return chance(24);
			default:       return 1'b0;
		endcase
	endfunction

	function automatic void add_byte(input logic [7:0] b);
		frame_bytes = {frame_bytes, b};
	endfunction

	initial begin
		in_ch.valid = 1'b0;
		in_ch.rx_byte = '0;
		in_ch.buffer_end = 1'b0;
		out_ch.ready = 1'b0;
	end

	always @(posedge clk)
		out_ch.ready <= !receiver_stalls();

	task automatic send_byte(input logic [7:0] b, input logic last);
		while (sender_idles()) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.rx_byte <= b;
		in_ch.buffer_end <= last;
		do @(posedge clk); while (!in_ch.ready);
		bytes_sent++;
	endtask

	task automatic build_frame(input logic [15:0] ver, input logic [7:0] kind,
		input logic [31:0] seq, input logic [31:0] len, input int body,
		input bit with_check, input int trailing, input logic [15:0] chk);
		frame_bytes.delete();
		add_byte(ver[15:8]);
		add_byte(ver[7:0]);
		add_byte(kind);
		for (int i = 3; i >= 0; i--)
			add_byte(seq[i*8 +: 8]);
		for (int i = 3; i >= 0; i--)
			add_byte(len[i*8 +: 8]);
		repeat (body) add_byte(8'($urandom));
		if (with_check) begin
			add_byte(chk[15:8]);
			add_byte(chk[7:0]);
		end
		repeat (trailing) add_byte(8'($urandom));
	endtask

	// sends the first keep bytes of the frame as one buffer
	task automatic send_buffer(input int keep);
		for (int i = 0; i < keep; i++)
			send_byte(frame_bytes[i], i == keep - 1);
	endtask

	task automatic random_buffer();
		int pick;
		int len;
		pick = $urandom_range(99);
		if (pick < 75) begin
			len = $urandom_range(12);
			build_frame(16'($urandom), 8'($urandom), $urandom, len, len, 1'b1,
				chance(20) ? $urandom_range(1, 3) : 0, 16'($urandom));
			if (pick < 60)
				send_buffer(frame_bytes.size());
			else
				send_buffer($urandom_range(1, frame_bytes.size() - 1));
		end else if (pick < 85) begin
			// arbitrary length field, buffer cut early
			build_frame(16'($urandom), 8'($urandom), $urandom, $urandom,
				$urandom_range(0, 6), 1'b0, 0, '0);
			send_buffer(frame_bytes.size());
		end else begin
			frame_bytes.delete();
			repeat ($urandom_range(1, 20)) add_byte(8'($urandom));
			send_buffer(frame_bytes.size());
		end
	endtask

	task automatic run_phase(input idle_mode_t m, input int nbytes);
		int target;
		idle_mode = m;
		target = bytes_sent + nbytes;
		while (bytes_sent < target)
			random_buffer();
	endtask

	initial begin
		int guard;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// minimal frame, empty payload, all-zero fields
		build_frame('0, '0, '0, 0, 0, 1'b1, 0, '0);
		send_buffer(frame_bytes.size());
		// all-ones fields, one payload byte, back to back
		build_frame('1, '1, '1, 1, 1, 1'b1, 0, '1);
		frame_bytes[11] = 8'hff;
		send_buffer(frame_bytes.size());
		// bytes after the frame are ignored
		build_frame(16'h1234, 8'h56, 32'h89abcdef, 2, 2, 1'b1, 2, 16'hbeef);
		send_buffer(frame_bytes.size());
		// single byte buffer, then 12 bytes: both too short
		send_byte(8'h80, 1'b1);
		build_frame(16'h0102, 8'h03, 32'h04050607, 0, 0, 1'b1, 0, 16'h0a0b);
		send_buffer(12);
		// ends on a payload byte: mismatch report, byte not passed on
		build_frame(16'hcafe, 8'h01, 32'h1, 5, 5, 1'b1, 0, 16'h5555);
		send_buffer(14);
		// ends on the first check byte
		build_frame(16'h0001, 8'h7f, 32'h7fffffff, 1, 1, 1'b1, 0, 16'haaaa);
		send_buffer(13);
		// maximal length field, truncated
		build_frame(16'h8000, 8'h80, 32'h80000000, 32'hffffffff, 3, 1'b0, 0, '0);
		send_buffer(frame_bytes.size());

		run_phase(IDLE_NONE, PHASE_BYTES);
		run_phase(IDLE_SENDER, PHASE_BYTES);
		run_phase(IDLE_RECEIVER, PHASE_BYTES);
		run_phase(IDLE_BOTH, PHASE_BYTES);

		in_ch.valid <= 1'b0;
		idle_mode = IDLE_NONE;
		guard = 0;
		while (outstanding != 0 && guard < 10000) begin
			@(posedge clk);
			guard++;
		end
		if (outstanding != 0) begin
			$display("** length_prefixed_packet_deframer_unit: FAILED **");
		end else begin
			repeat (4) @(posedge clk);
			if (mismatches == 0 && outstanding == 0) begin
				$display("** length_prefixed_packet_deframer_unit: PASSED **");
			end else begin
				$display("** length_prefixed_packet_deframer_unit: FAILED **");
			end
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("** length_prefixed_packet_deframer_unit: FAILED **");
		$finish;
	end

endmodule

@@ sim.f @@
src/lppd_pkg.sv
src/lppd_in_if.sv
src/lppd_out_if.sv
src/lppd_parser.sv
src/lppd_out_reg.sv
src/length_prefixed_packet_deframer_unit.sv
src/lppd_checker.sv
dv/lppd_frame_checker.sv
dv/length_prefixed_packet_deframer_unit_test.sv
